### hdl/mha_pkg.sv
// Shared types, constants and arctangent table for the magnetometer heading pipeline.
package mha_pkg;

    // Output angle resolution in fractional bits of a degree.
    localparam int ANGLE_FRACTION_BITS = 6;
    // Requested CORDIC iterations; the table limits how many really run.
    localparam int CORDIC_STAGES       = 16;
    localparam int TABLE_LEN           = 24;
    localparam int NUM_STAGES          = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // Internal fixed point: 20 fractional bits on vectors and angles.
    localparam int INT_FRAC  = 20;
    localparam int SAMPLE_W  = 16;
    localparam int HEADING_W = 15;
    // Vector width: sample, four extension bits for the negation of the most
    // negative code and for CORDIC growth, and the fraction.
    localparam int VEC_W     = SAMPLE_W + 4 + INT_FRAC;
    localparam int ACC_W     = 32;

    localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
    localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = ACC_W'(180 * (1 << INT_FRAC));
    localparam logic signed [ACC_W-1:0] ACC_FULL_TURN = ACC_W'(360 * (1 << INT_FRAC));

    localparam int ROUND_SHIFT = INT_FRAC - ANGLE_FRACTION_BITS;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);

    localparam int HEADING_TOP = 360 * (1 << ANGLE_FRACTION_BITS);
    localparam logic [HEADING_W-1:0] HEADING_MAX =
        (HEADING_TOP > (1 << HEADING_W) - 1) ? {HEADING_W{1'b1}} : HEADING_W'(HEADING_TOP);

    // round(atan(2^-i) * 180/pi * 2^20)
    localparam logic signed [ACC_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
    } mha_vec_t;

endpackage

### hdl/mha_prerot.sv
// Input stage: scales the samples and folds the left half plane onto the right.
module mha_prerot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_vld,
    input  logic signed [mha_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [mha_pkg::SAMPLE_W-1:0] y_sample,
    output logic                           vld,
    output mha_pkg::mha_vec_t              vec
);

    localparam int EXT_W = mha_pkg::VEC_W - mha_pkg::INT_FRAC - mha_pkg::SAMPLE_W;

    logic signed [mha_pkg::VEC_W-1:0] x_ext;
    logic signed [mha_pkg::VEC_W-1:0] y_ext;
    mha_pkg::mha_vec_t                vec_next;
    mha_pkg::mha_vec_t                vec_reg;
    logic                             vld_reg;

    assign x_ext = {{EXT_W{x_sample[mha_pkg::SAMPLE_W-1]}}, x_sample, {mha_pkg::INT_FRAC{1'b0}}};
    assign y_ext = {{EXT_W{y_sample[mha_pkg::SAMPLE_W-1]}}, y_sample, {mha_pkg::INT_FRAC{1'b0}}};

    always_comb
    begin
        if (x_sample[mha_pkg::SAMPLE_W-1])
        begin
            vec_next.x   = -x_ext;
            vec_next.y   = -y_ext;
            vec_next.acc = y_sample[mha_pkg::SAMPLE_W-1] ? mha_pkg::ACC_ZERO
                                                         : mha_pkg::ACC_FULL_TURN;
        end
        else
        begin
            vec_next.x   = x_ext;
            vec_next.y   = y_ext;
            vec_next.acc = mha_pkg::ACC_HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vld = vld_reg;
    assign vec = vec_reg;

`ifndef NO_ASSERTIONS
    // After folding, the vector always points into the right half plane.
    a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> !vec_reg.x[mha_pkg::VEC_W-1])
        else $error("pre-rotated x is negative");

    // The base angle is one of the three quadrant starting points.
    a_base_angle: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (vec_reg.acc == mha_pkg::ACC_ZERO || vec_reg.acc == mha_pkg::ACC_HALF_TURN
                     || vec_reg.acc == mha_pkg::ACC_FULL_TURN))
        else $error("pre-rotation base angle out of set");
`endif

endmodule

### hdl/mha_cordic.sv
// Pipelined CORDIC vectoring iterations, one registered iteration per stage.
module mha_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_vld,
    input  mha_pkg::mha_vec_t vec_in,
    output logic              vld,
    output mha_pkg::mha_vec_t vec
);

    localparam int N = mha_pkg::NUM_STAGES;

    logic [N-1:0]      vld_reg;
    logic [N-1:0]      vld_prev;
    mha_pkg::mha_vec_t stage_in   [0:N-1];
    mha_pkg::mha_vec_t stage_next [0:N-1];
    mha_pkg::mha_vec_t data_reg   [0:N-1];

    assign vld_prev = {vld_reg[N-2:0], in_vld};

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic signed [mha_pkg::VEC_W-1:0] dx;
            logic signed [mha_pkg::VEC_W-1:0] dy;

            if (g == 0)
            begin : g_first
                assign stage_in[g] = vec_in;
            end
            else
            begin : g_rest
                assign stage_in[g] = data_reg[g-1];
            end

            assign dx = $signed(stage_in[g].y) >>> g;
            assign dy = $signed(stage_in[g].x) >>> g;

            always_comb
            begin
                if (!stage_in[g].y[mha_pkg::VEC_W-1])
                begin
                    stage_next[g].x   = stage_in[g].x + dx;
                    stage_next[g].y   = stage_in[g].y - dy;
                    stage_next[g].acc = stage_in[g].acc + mha_pkg::ATAN_TABLE[g];
                end
                else
                begin
                    stage_next[g].x   = stage_in[g].x - dx;
                    stage_next[g].y   = stage_in[g].y + dy;
                    stage_next[g].acc = stage_in[g].acc - mha_pkg::ATAN_TABLE[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    data_reg[g] <= stage_next[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_prev;
        end
    end

    assign vld = vld_reg[N-1];
    assign vec = data_reg[N-1];

`ifndef NO_ASSERTIONS
    // Valid bits shift one stage on each advance.
    a_vld_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (vld_reg == $past(vld_prev)))
        else $error("valid bits did not shift with the data");

    // A held pipeline keeps every valid bit.
    a_vld_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("valid bits changed while the pipeline was held");
`endif

endmodule

### hdl/mha_final.sv
// Output stage: clamps the angle to one turn, rounds it and holds the result.
module mha_final (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_vld,
    input  mha_pkg::mha_vec_t               vec_in,
    output logic                            vld,
    output logic [mha_pkg::HEADING_W-1:0]   heading
);

    logic [mha_pkg::ACC_W-1:0]     clamped;
    logic [mha_pkg::ACC_W-1:0]     rounded;
    logic [mha_pkg::HEADING_W-1:0] heading_next;
    logic [mha_pkg::HEADING_W-1:0] heading_reg;
    logic                          vld_reg;

    always_comb
    begin
        if (vec_in.acc[mha_pkg::ACC_W-1])
        begin
            clamped = '0;
        end
        else if (vec_in.acc > mha_pkg::ACC_FULL_TURN)
        begin
            clamped = mha_pkg::ACC_FULL_TURN;
        end
        else
        begin
            clamped = vec_in.acc;
        end
        rounded      = (clamped + mha_pkg::ROUND_HALF) >> mha_pkg::ROUND_SHIFT;
        heading_next = rounded[mha_pkg::HEADING_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            heading_reg <= heading_next;
        end
    end

    assign vld     = vld_reg;
    assign heading = heading_reg;

`ifndef NO_ASSERTIONS
    // Clamping keeps every delivered heading within one full turn.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (heading_reg <= mha_pkg::HEADING_MAX))
        else $error("heading beyond one full turn");
`endif

endmodule

### hdl/magnetometer_heading_atan2.sv
// Top level of the magnetometer heading unit: atan2 by a pipelined CORDIC.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+---------------------------------------
//   input   | in_valid, in_stall | x_sample, y_sample (signed 16 bits)
//   output  | out_valid, out_stall | heading (unsigned 15 bits)
//
// One transfer enters per cycle while in_stall is low. The pipeline has one
// fold stage, one stage per CORDIC iteration, and one clamp and round stage
// that doubles as the output register.
// Reset clears every valid bit; the data registers are not reset.
// The whole pipeline advances together whenever the output register is empty
// or its transfer completes; otherwise every stage holds and in_stall is high.
//
// The heading is atan2(y, x) plus 180 degrees in units of 1/64 degree,
// 0 to 23040, rounded to nearest; both samples zero give 17912 (279.875 degrees).
module magnetometer_heading_atan2 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [mha_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [mha_pkg::SAMPLE_W-1:0] y_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mha_pkg::HEADING_W-1:0]       heading
);

    logic              advance;
    logic              pre_vld;
    mha_pkg::mha_vec_t pre_vec;
    logic              cor_vld;
    mha_pkg::mha_vec_t cor_vec;

    // The pipeline moves as one shift register; a waiting result stops it.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Fold the left half plane and set the base angle.
    mha_prerot u_prerot (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (in_valid),
        .x_sample (x_sample),
        .y_sample (y_sample),
        .vld      (pre_vld),
        .vec      (pre_vec)
    );

    // Rotate the vector onto the x axis, summing the rotation angles.
    mha_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_vld  (pre_vld),
        .vec_in  (pre_vec),
        .vld     (cor_vld),
        .vec     (cor_vec)
    );

    // Clamp to one turn and round to the output resolution.
    mha_final u_final (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_vld  (cor_vld),
        .vec_in  (cor_vec),
        .vld     (out_valid),
        .heading (heading)
    );

endmodule

### tb/magnetometer_heading_atan2_tb.sv
// Self-checking testbench for the CORDIC compass heading block, with a bit-exact predictor.
`timescale 1ns / 100ps

module magnetometer_heading_atan2_tb;

    // Port widths of the block under test.
    localparam int SAMPLE_W     = mha_pkg::SAMPLE_W;
    localparam int HEADING_W    = mha_pkg::HEADING_W;
    // Cycles from an accepted sample pair to its heading at the output port.
    localparam int PIPE_LATENCY = mha_pkg::NUM_STAGES + 2;
    // Fixed point used by the predictor: degrees and vectors scaled by 2^20.
    localparam int FIX_FRAC     = 20;
    localparam int ARCTAN_LEN   = 24;
    localparam int ITERATIONS   = (mha_pkg::CORDIC_STAGES < ARCTAN_LEN) ?
                                  mha_pkg::CORDIC_STAGES : ARCTAN_LEN;
    localparam longint TURN_FIX = longint'(360) <<< FIX_FRAC;
    localparam longint HALF_FIX = longint'(180) <<< FIX_FRAC;
    // Idle rate of both sides, in percent of cycles.
    localparam int IDLE_PCT     = 11;
    // Output hold-off that forces the pipeline to fill and stall its input.
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT      = 400;
    // Window of transfers in which neither side idles.
    localparam int QUIET_LO     = 800;
    localparam int QUIET_HI     = 1000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } field_pair_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  x_sample  = '0;
    logic signed [SAMPLE_W-1:0]  y_sample  = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [HEADING_W-1:0]        heading;

    // Sample pairs waiting to be offered, and headings waiting to come out.
    field_pair_t          pending_pairs [$];
    logic [HEADING_W-1:0] heading_due [$];

    int accepted_cnt   = 0;
    int checked_cnt    = 0;
    int mismatch_cnt   = 0;
    int unexpected_cnt = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // round(atan(2^-i) * 180/pi * 2^20), one entry per micro-rotation.
    longint arctan_deg [0:ARCTAN_LEN-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    magnetometer_heading_atan2 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_sample  (x_sample),
        .y_sample  (y_sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading)
    );

    always #5 clk = ~clk;

    // Heading of one X/Y pair by CORDIC vectoring in wide signed arithmetic.
    // A vector in the left half plane is turned by 180 degrees first, so the
    // iterations only ever see x >= 0; the base angle then depends on which
    // side of the X axis the original vector lay (y = 0 lands on 360).
    function automatic logic [HEADING_W-1:0] cordic_heading(
        input logic signed [SAMPLE_W-1:0] xs,
        input logic signed [SAMPLE_W-1:0] ys
    );
        longint vx;
        longint vy;
        longint dx;
        longint dy;
        longint angle;
        longint rounded;
        vx = longint'(xs) * (longint'(1) <<< FIX_FRAC);
        vy = longint'(ys) * (longint'(1) <<< FIX_FRAC);
        if (vx < 0)
        begin
            angle = (vy >= 0) ? TURN_FIX : 0;
            vx    = -vx;
            vy    = -vy;
        end
        else
        begin
            angle = HALF_FIX;
        end
        for (int i = 0; i < ITERATIONS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx    = vx + dx;
                vy    = vy - dy;
                angle = angle + arctan_deg[i];
            end
            else
            begin
                vx    = vx - dx;
                vy    = vy + dy;
                angle = angle - arctan_deg[i];
            end
        end
        // The last micro-rotation may overshoot slightly past either end.
        if (angle < 0)
            angle = 0;
        if (angle > TURN_FIX)
            angle = TURN_FIX;
        rounded = (angle + (longint'(1) <<< (FIX_FRAC - 1 - mha_pkg::ANGLE_FRACTION_BITS)))
                  >>> (FIX_FRAC - mha_pkg::ANGLE_FRACTION_BITS);
        return HEADING_W'(rounded);
    endfunction

    // Random pair drawn from a mix of shapes: mostly full-range noise, plus
    // tiny vectors where the CORDIC shifts run out of bits, vectors on an
    // axis, vectors hugging the negative X axis where the angle wraps and
    // clamps, and samples pinned at the ends of their range.
    function automatic field_pair_t random_pair();
        field_pair_t p;
        int          pick;
        pick = $urandom_range(99);
        p.x  = SAMPLE_W'($urandom);
        p.y  = SAMPLE_W'($urandom);
        if (pick < 15)
        begin
            p.x = SAMPLE_W'($urandom_range(16) - 8);
            p.y = SAMPLE_W'($urandom_range(16) - 8);
        end
        else if (pick < 25)
        begin
            if ($urandom_range(1))
                p.x = '0;
            else
                p.y = '0;
        end
        else if (pick < 35)
        begin
            p.x = -SAMPLE_W'($urandom_range(32767, 1));
            p.y = SAMPLE_W'($urandom_range(4) - 2);
        end
        else if (pick < 50)
        begin
            case ($urandom_range(3))
                0: p.x = 16'sh7fff;
                1: p.x = 16'sh8000;
                2: p.y = 16'sh7fff;
                default: p.y = 16'sh8000;
            endcase
        end
        return p;
    endfunction

    // Sender. The predicted heading is queued at the edge where the transfer
    // completes; a new pair is offered only when nothing is held on the port,
    // so a stalled payload never changes and in_valid is assigned once a step.
    always @(posedge clk)
    begin
        logic        offer;
        field_pair_t next_pair;
        offer     = 1'b0;
        next_pair = '0;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                heading_due.push_back(cordic_heading(x_sample, y_sample));
                accepted_cnt++;
            end
            if (pending_pairs.size() != 0)
            begin
                offer = (accepted_cnt >= QUIET_LO && accepted_cnt < QUIET_HI) ||
                        ($urandom_range(99) >= IDLE_PCT);
                if (offer)
                    next_pair = pending_pairs.pop_front();
            end
            in_valid <= offer;
            if (offer)
            begin
                x_sample <= next_pair.x;
                y_sample <= next_pair.y;
            end
        end
    end

    // Receiver. Checks every completed output transfer against the oldest
    // prediction, then picks the stall for the next cycle. Once, after
    // HOLD_AT headings, it stalls the output through a HOLD_CYCLES countdown
    // so the pipeline fills while the sender keeps offering pairs.
    always @(posedge clk)
    begin
        logic                 hold_off;
        logic [HEADING_W-1:0] want;
        hold_off = 1'b0;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (heading_due.size() == 0)
                begin
                    unexpected_cnt++;
                    if (unexpected_cnt + mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: heading %0d arrived with none outstanding",
                                 $realtime, heading);
                end
                else
                begin
                    want = heading_due.pop_front();
                    checked_cnt++;
                    if (heading !== want)
                    begin
                        mismatch_cnt++;
                        if (unexpected_cnt + mismatch_cnt <= REPORT_LIMIT)
                            $display("%0t: heading #%0d expected %0d, got %0d",
                                     $realtime, checked_cnt, want, heading);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                hold_off  = 1'b1;
            end
            else if (!hold_done && checked_cnt >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                hold_off  = 1'b1;
            end
            else if (!(checked_cnt >= QUIET_LO && checked_cnt < QUIET_HI))
            begin
                hold_off = ($urandom_range(99) < IDLE_PCT);
            end
            out_stall <= hold_off;
        end
    end

    // Blocks until the sender has handed over every queued pair and every
    // predicted heading has been checked.
    task automatic drain_pipeline();
        while (pending_pairs.size() != 0 || in_valid || heading_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_pair(input int xv, input int yv);
        field_pair_t p;
        p.x = SAMPLE_W'(xv);
        p.y = SAMPLE_W'(yv);
        pending_pairs.push_back(p);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners: the zero vector, both axes in both directions,
        // full-scale samples in every quadrant, the negative X axis where
        // the top code comes out, and vectors just off that axis where the
        // angle lands next to 0 or 360 and the overshoot gets clamped.
        queue_pair(0, 0);
        queue_pair(32767, 0);
        queue_pair(-32768, 0);
        queue_pair(-1, 0);
        queue_pair(1, 0);
        queue_pair(0, 32767);
        queue_pair(0, -32768);
        queue_pair(0, 1);
        queue_pair(0, -1);
        queue_pair(32767, 32767);
        queue_pair(-32768, -32768);
        queue_pair(-32768, 32767);
        queue_pair(32767, -32768);
        queue_pair(-1, -1);
        queue_pair(-1, 1);
        queue_pair(1, -1);
        queue_pair(-32768, 1);
        queue_pair(-32768, -1);
        queue_pair(-5, -1);
        queue_pair(-32767, 2);
        queue_pair(12345, -23456);
        drain_pipeline();

        // First random batch; the output hold-off falls inside it. The
        // sender then sits idle until every heading has come back.
        repeat (600) pending_pairs.push_back(random_pair());
        drain_pipeline();

        // Second random batch, which also spans the window with no idling.
        repeat (630) pending_pairs.push_back(random_pair());
        drain_pipeline();
        repeat (PIPE_LATENCY + 20) @(posedge clk);

        $display("Sent %0d sample pairs and checked %0d headings, including a %0d-cycle",
                 accepted_cnt, checked_cnt, HOLD_CYCLES);
        $display("output hold-off; %0d mismatches, %0d unexpected headings.",
                 mismatch_cnt, unexpected_cnt);
        if (mismatch_cnt == 0 && unexpected_cnt == 0 && heading_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 1250 transfers.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d headings still outstanding.", heading_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/mha_pkg.sv
hdl/mha_prerot.sv
hdl/mha_cordic.sv
hdl/mha_final.sv
hdl/magnetometer_heading_atan2.sv
tb/magnetometer_heading_atan2_tb.sv
